### design/pwmt_pkg.sv
// Shared types and constants for the PWM timer channel.
package pwmt_pkg;

  localparam int COUNTER_WIDTH_DEF = 16;
  localparam int REG_W             = 16;
  localparam int CFG_IDX_W         = 3;
  localparam int IN_DATA_W         = 16;
  localparam int IN_USER_W         = 2;
  localparam int OUT_DATA_W        = 40;

  localparam logic [6:0] DUTY_MAX = 7'd100;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_RAW   = 2'd1,
    MODE_DUTY  = 2'd2,
    MODE_FORCE = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESCALER   = 3'd0,
    CFG_AUTO_RELOAD = 3'd1,
    CFG_PRELOAD_EN  = 3'd2,
    CFG_OUTPUT_EN   = 3'd3,
    CFG_COUNTER_EN  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [REG_W-1:0] prescaler;
    logic [REG_W-1:0] auto_reload;
    logic             preload_en;
    logic             output_en;
    logic             counter_en;
  } cfg_t;

  // Member order puts pwm_level in the lowest bit when packed.
  typedef struct packed {
    logic [15:0] active_compare;
    logic        update_flag;
    logic [15:0] count;
    logic        pwm_level;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

### design/pwmt_step.sv
// Timer state registers and the combinational step that processes one item.
module pwmt_step #(
  parameter int COUNTER_WIDTH = pwmt_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step_en,
  input  pwmt_pkg::mode_t              mode,
  input  logic [pwmt_pkg::REG_W-1:0]   value,
  input  pwmt_pkg::cfg_t               cfg,
  output pwmt_pkg::result_t            result
);
  import pwmt_pkg::*;

  localparam int CW = COUNTER_WIDTH;
  localparam int MW = (CW > REG_W) ? CW : REG_W;

  logic [REG_W-1:0] psc_cnt_r, psc_cnt_nxt;
  logic [CW-1:0]    main_cnt_r, main_cnt_nxt;
  logic [REG_W-1:0] psc_shadow_r, psc_shadow_nxt;
  logic [REG_W-1:0] arr_shadow_r, arr_shadow_nxt;
  logic [REG_W-1:0] ccr_buf_r, ccr_buf_nxt;
  logic [REG_W-1:0] ccr_eff_r, ccr_eff_nxt;

  logic [6:0]       duty_clamped;
  logic [6:0]       duty_gap;
  logic [REG_W-1:0] duty_ccr;
  logic [REG_W-1:0] ccr_wr;
  logic             ccr_we;
  logic             upd;
  logic [MW-1:0]    main_ext;
  logic [MW-1:0]    main_nxt_ext;
  logic [MW-1:0]    arr_ext;
  logic [MW-1:0]    ccr_nxt_ext;

  // Duty percent to compare: (100 - duty) * 10 as two shifted adds.
  always_comb begin
    duty_clamped = (value > REG_W'(DUTY_MAX)) ? DUTY_MAX : value[6:0];
    duty_gap     = DUTY_MAX - duty_clamped;
    duty_ccr     = REG_W'({duty_gap, 3'b000}) + REG_W'({duty_gap, 1'b0});
  end

  always_comb begin
    main_ext = MW'(main_cnt_r);
    arr_ext  = MW'(arr_shadow_r);

    psc_cnt_nxt    = psc_cnt_r;
    main_cnt_nxt   = main_cnt_r;
    upd            = 1'b0;
    ccr_we         = 1'b0;
    ccr_wr         = value;

    case (mode)
      MODE_TICK: begin
        if (cfg.counter_en) begin
          if (psc_cnt_r >= psc_shadow_r) begin
            psc_cnt_nxt = '0;
            if (main_ext >= arr_ext) begin
              main_cnt_nxt = '0;
              upd          = 1'b1;
            end else begin
              main_cnt_nxt = main_cnt_r + CW'(1);
            end
          end else begin
            psc_cnt_nxt = psc_cnt_r + REG_W'(1);
          end
        end
      end
      MODE_RAW: begin
        ccr_we = 1'b1;
      end
      MODE_DUTY: begin
        ccr_we = 1'b1;
        ccr_wr = duty_ccr;
      end
      MODE_FORCE: begin
        psc_cnt_nxt  = '0;
        main_cnt_nxt = '0;
        upd          = 1'b1;
      end
      default: begin
        psc_cnt_nxt = psc_cnt_r;
      end
    endcase

    ccr_buf_nxt    = ccr_we ? ccr_wr : ccr_buf_r;
    ccr_eff_nxt    = (ccr_we && !cfg.preload_en) ? ccr_wr : ccr_eff_r;
    psc_shadow_nxt = psc_shadow_r;
    arr_shadow_nxt = arr_shadow_r;
    if (upd) begin
      psc_shadow_nxt = cfg.prescaler;
      arr_shadow_nxt = cfg.auto_reload;
      ccr_eff_nxt    = ccr_buf_r;
    end
  end

  // The result reflects the state after this item.
  always_comb begin
    main_nxt_ext          = MW'(main_cnt_nxt);
    ccr_nxt_ext           = MW'(ccr_eff_nxt);
    result.pwm_level      = cfg.output_en && (main_nxt_ext < ccr_nxt_ext);
    result.count          = 16'(main_cnt_nxt);
    result.update_flag    = upd;
    result.active_compare = ccr_eff_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psc_cnt_r    <= '0;
      main_cnt_r   <= '0;
      psc_shadow_r <= '0;
      arr_shadow_r <= '1;
      ccr_buf_r    <= '0;
      ccr_eff_r    <= '0;
    end else if (step_en) begin
      psc_cnt_r    <= psc_cnt_nxt;
      main_cnt_r   <= main_cnt_nxt;
      psc_shadow_r <= psc_shadow_nxt;
      arr_shadow_r <= arr_shadow_nxt;
      ccr_buf_r    <= ccr_buf_nxt;
      ccr_eff_r    <= ccr_eff_nxt;
    end
  end

endmodule

### design/pwm_timer_channel_core.sv
// Top level of the up-counting PWM timer channel with preloaded compare.
//
// This block models one channel of an up-counting timer in PWM mode 1 with
// active-high output. Each transfer on the input stream is one action, chosen
// by in_tuser: a clock tick, a raw compare write, a duty-percent write, or a
// forced update event; in_tdata carries the compare value or the percent.
// Every input transfer yields exactly one output transfer with the output
// level, the counter, an update marker and the compare value in effect. An
// item passes through an input register and then one stage of logic into the
// output register, so the block takes one item per clock cycle when the output
// is not stalled by out_tready. An accepted item is held in the input register,
// and its result is then offered on out_tvalid from the output register.
// Prescaler and reload values written through the configuration port take
// effect at the next update event; the compare value does too when preload is
// enabled. The user must write configuration only while no item is in flight;
// the block itself does not enforce this.
module pwm_timer_channel_core #(
  parameter int COUNTER_WIDTH = pwmt_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [pwmt_pkg::IN_DATA_W-1:0]    in_tdata,   // [15:0] value
  input  logic [pwmt_pkg::IN_USER_W-1:0]    in_tuser,   // [1:0] mode
  // Result stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] pwm_level, [16:1] count, [17] update_flag, [33:18] active_compare,
  // [39:34] zero
  output logic [pwmt_pkg::OUT_DATA_W-1:0]   out_tdata,
  // Configuration write port.
  input  logic                              cfg_wr_en,
  input  logic [pwmt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pwmt_pkg::REG_W-1:0]        cfg_wdata
);
  import pwmt_pkg::*;

  cfg_t             cfg_r;

  // Input register stage.
  logic             in_vld_r;
  mode_t            mode_r;
  logic [REG_W-1:0] value_r;

  // Output register stage.
  logic             out_vld_r;
  result_t          res_r;
  result_t          res_nxt;

  logic             out_free;
  logic             adv;

  // The step stage advances when it holds an item and the output register is
  // free or is being drained by a transfer in this same cycle.
  assign out_free  = !out_vld_r || out_tready;
  assign adv       = in_vld_r && out_free;
  assign in_tready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prescaler   <= '0;
      cfg_r.auto_reload <= '1;
      cfg_r.preload_en  <= 1'b0;
      cfg_r.output_en   <= 1'b0;
      cfg_r.counter_en  <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PRESCALER:   cfg_r.prescaler   <= cfg_wdata;
        CFG_AUTO_RELOAD: cfg_r.auto_reload <= cfg_wdata;
        CFG_PRELOAD_EN:  cfg_r.preload_en  <= cfg_wdata[0];
        CFG_OUTPUT_EN:   cfg_r.output_en   <= cfg_wdata[0];
        CFG_COUNTER_EN:  cfg_r.counter_en  <= cfg_wdata[0];
        default: begin
          // Writes to unused indexes are dropped.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      mode_r  <= mode_t'(in_tuser);
      value_r <= in_tdata;
    end
  end

  pwmt_step #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .mode    (mode_r),
    .value   (value_r),
    .cfg     (cfg_r),
    .result  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= adv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(OUT_DATA_W - RESULT_W)'(0), res_r};

  // An update event always leaves the counter at zero.
  a_update_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_r.update_flag |-> res_r.count == 16'd0)
    else $error("update event reported with a nonzero count");

  // A high level needs a nonzero compare value in effect.
  a_high_needs_compare: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_r.pwm_level |-> res_r.active_compare != 16'd0)
    else $error("output high with zero compare");

  // An item held in the input stage while the output is stalled stays there.
  a_input_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !out_free |=> in_vld_r && $stable(value_r))
    else $error("input stage lost an item during a stall");

endmodule
